// File: design/lifeca_pkg.sv
`timescale 1ns / 1ps

package lifeca_pkg;

    localparam int GRID_SIDE = 64;
    localparam int ROW_W     = $clog2(GRID_SIDE);
    localparam int IDX_W     = 6;
    localparam int FUNC_W    = 3;
    localparam int CNT_W     = 4;

    typedef logic [GRID_SIDE-1:0] t_row;

    typedef enum logic [FUNC_W-1:0] {
        FN_TOGGLE    = 3'd0,
        FN_ADVANCE   = 3'd1,
        FN_STARTSTOP = 3'd2,
        FN_CLEAR     = 3'd3,
        FN_READ      = 3'd4
    } t_func;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  row_index;
        logic [IDX_W-1:0]  col_index;
    } t_in_item;

    typedef struct packed {
        logic             cell_alive;
        logic [CNT_W-1:0] neighbor_count;
        logic             running;
        logic             rejected;
    } t_out_item;

    typedef enum logic [2:0] {
        RA_UP,
        RA_DOWN,
        RA_FIRST,
        RA_NEXT1,
        RA_NEXT2
    } t_rda_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TGL_RD,
        ST_TGL_WR,
        ST_ADV_LOAD,
        ST_ADV_INIT,
        ST_ADV_ROW,
        ST_REP_RD,
        ST_REP_CAP,
        ST_REP_OUT
    } t_state;

    typedef struct packed {
        logic     load_item;
        logic     rd_a_en;
        t_rda_sel rd_a_sel;
        logic     rd_b_en;
        logic     wr_toggle;
        logic     wr_advance;
        logic     clear;
        logic     sweep_start;
        logic     win_init;
        logic     rep_capture;
        logic     out_load;
        logic     running;
        logic     rejected;
    } t_dp_cmd;

    typedef struct packed {
        logic last_row;
        logic out_free;
    } t_dp_stat;

endpackage

// File: design/lifeca_ctrl.sv
`timescale 1ns / 1ps

module lifeca_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [lifeca_pkg::FUNC_W-1:0] i_func,
    input  lifeca_pkg::t_dp_stat       i_stat,
    output logic                       o_busy,
    output lifeca_pkg::t_dp_cmd        o_cmd
);
    import lifeca_pkg::*;

    t_state r_state, n_state;
    logic   r_run, n_run;
    logic   r_rejected, n_rejected;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_run      <= 1'b0;
            r_rejected <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_run      <= n_run;
            r_rejected <= n_rejected;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_run      = r_run;
        n_rejected = r_rejected;
        o_busy     = 1'b1;
        o_cmd      = '0;
        o_cmd.rd_a_sel = RA_UP;
        o_cmd.running  = r_run;
        o_cmd.rejected = r_rejected;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_rejected      = 1'b0;
                    n_state         = ST_REP_RD;
                    case (i_func)
                        FN_TOGGLE: begin
                            if (r_run) begin
                                n_rejected = 1'b1;
                            end else begin
                                n_state = ST_TGL_RD;
                            end
                        end
                        FN_ADVANCE: begin
                            if (r_run) begin
                                n_state = ST_ADV_LOAD;
                            end
                        end
                        FN_STARTSTOP: begin
                            n_run = ~r_run;
                        end
                        FN_CLEAR: begin
                            o_cmd.clear = 1'b1;
                            n_run       = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_TGL_RD: begin
                o_cmd.rd_b_en = 1'b1;
                n_state       = ST_TGL_WR;
            end
            ST_TGL_WR: begin
                o_cmd.wr_toggle = 1'b1;
                n_state         = ST_REP_RD;
            end
            ST_ADV_LOAD: begin
                o_cmd.rd_a_en     = 1'b1;
                o_cmd.rd_a_sel    = RA_FIRST;
                o_cmd.sweep_start = 1'b1;
                n_state           = ST_ADV_INIT;
            end
            ST_ADV_INIT: begin
                o_cmd.win_init = 1'b1;
                o_cmd.rd_a_en  = 1'b1;
                o_cmd.rd_a_sel = RA_NEXT1;
                n_state        = ST_ADV_ROW;
            end
            ST_ADV_ROW: begin
                o_cmd.wr_advance = 1'b1;
                o_cmd.rd_a_en    = 1'b1;
                o_cmd.rd_a_sel   = RA_NEXT2;
                if (i_stat.last_row) begin
                    n_state = ST_REP_RD;
                end
            end
            ST_REP_RD: begin
                o_cmd.rd_a_en  = 1'b1;
                o_cmd.rd_a_sel = RA_UP;
                o_cmd.rd_b_en  = 1'b1;
                n_state        = ST_REP_CAP;
            end
            ST_REP_CAP: begin
                o_cmd.rep_capture = 1'b1;
                o_cmd.rd_a_en     = 1'b1;
                o_cmd.rd_a_sel    = RA_DOWN;
                n_state           = ST_REP_OUT;
            end
            ST_REP_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/lifeca_dp.sv
`timescale 1ns / 1ps

module lifeca_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lifeca_pkg::t_in_item  i_item,
    input  lifeca_pkg::t_dp_cmd   i_cmd,
    input  logic                  i_out_stall,
    output lifeca_pkg::t_dp_stat  o_stat,
    output logic                  o_out_valid,
    output lifeca_pkg::t_out_item o_out_item
);
    import lifeca_pkg::*;

    localparam logic [CNT_W-1:0] BIRTH_COUNT   = CNT_W'(3);
    localparam logic [CNT_W-1:0] SURVIVE_COUNT = CNT_W'(2);

    function automatic logic [CNT_W-1:0] f_count(input logic [7:0] bits);
        logic [CNT_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < 8; i++) begin
            sum = sum + CNT_W'(bits[i]);
        end
        return sum;
    endfunction

    t_row             r_grid [GRID_SIDE];
    t_row             r_row_vld;
    t_row             r_rd_a;
    t_row             r_rd_b;
    t_row             r_above;
    t_row             r_same;
    logic [IDX_W-1:0] r_row;
    logic [IDX_W-1:0] r_col;
    logic [ROW_W-1:0] r_k;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [ROW_W-1:0] w_row_a;
    logic [ROW_W-1:0] w_col_a;
    logic [ROW_W-1:0] w_rd_a_addr;
    logic             w_in_grid;
    logic             w_row_last;
    logic             w_k_last;
    t_row             w_below_sweep;
    t_row             w_below_rep;
    t_row             w_next_row;
    logic             w_wr_en;
    logic [ROW_W-1:0] w_wr_addr;
    t_row             w_wr_data;
    logic [GRID_SIDE+1:0] w_ext_a;
    logic [GRID_SIDE+1:0] w_ext_s;
    logic [GRID_SIDE+1:0] w_ext_b;
    logic [GRID_SIDE+1:0] w_ext_rb;
    logic [2:0]       w_win_a;
    logic [2:0]       w_win_s;
    logic [2:0]       w_win_b;
    logic [CNT_W-1:0] w_rep_count;
    t_out_item        w_result;

    assign w_row_a    = ROW_W'(r_row);
    assign w_col_a    = ROW_W'(r_col);
    assign w_in_grid  = (int'(r_row) < GRID_SIDE) && (int'(r_col) < GRID_SIDE);
    assign w_row_last = (int'(r_row) >= GRID_SIDE - 1);
    assign w_k_last   = (r_k == ROW_W'(GRID_SIDE - 1));

    assign w_below_sweep = w_k_last ? '0 : r_rd_a;
    assign w_below_rep   = w_row_last ? '0 : r_rd_a;

    always_comb begin
        case (i_cmd.rd_a_sel)
            RA_UP:    w_rd_a_addr = w_row_a - ROW_W'(1);
            RA_DOWN:  w_rd_a_addr = w_row_a + ROW_W'(1);
            RA_FIRST: w_rd_a_addr = '0;
            RA_NEXT1: w_rd_a_addr = r_k + ROW_W'(1);
            RA_NEXT2: w_rd_a_addr = r_k + ROW_W'(2);
            default:  w_rd_a_addr = '0;
        endcase
    end

    // Next generation of the swept row from the old rows above, at and below it.
    always_comb begin
        logic [CNT_W-1:0] n;
        w_ext_a = {1'b0, r_above, 1'b0};
        w_ext_s = {1'b0, r_same, 1'b0};
        w_ext_b = {1'b0, w_below_sweep, 1'b0};
        for (int c = 0; c < GRID_SIDE; c++) begin
            n = f_count({w_ext_a[c +: 3], w_ext_s[c + 2], w_ext_s[c], w_ext_b[c +: 3]});
            w_next_row[c] = (n == BIRTH_COUNT) || (r_same[c] && (n == SURVIVE_COUNT));
        end
    end

    assign w_wr_en   = i_cmd.wr_advance || (i_cmd.wr_toggle && w_in_grid);
    assign w_wr_addr = i_cmd.wr_advance ? r_k : w_row_a;
    assign w_wr_data = i_cmd.wr_advance ? w_next_row : (r_rd_b ^ (t_row'(1) << w_col_a));

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_grid[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_a_en) begin
            r_rd_a <= r_row_vld[w_rd_a_addr] ? r_grid[w_rd_a_addr] : '0;
        end
        if (i_cmd.rd_b_en) begin
            r_rd_b <= r_row_vld[w_row_a] ? r_grid[w_row_a] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_cmd.clear) begin
            r_row_vld <= '0;
        end else if (w_wr_en) begin
            r_row_vld[w_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_row <= i_item.row_index;
            r_col <= i_item.col_index;
        end
        if (i_cmd.sweep_start) begin
            r_k <= '0;
        end else if (i_cmd.wr_advance) begin
            r_k <= r_k + ROW_W'(1);
        end
        if (i_cmd.win_init) begin
            r_above <= '0;
            r_same  <= r_rd_a;
        end else if (i_cmd.wr_advance) begin
            r_above <= r_same;
            r_same  <= w_below_sweep;
        end else if (i_cmd.rep_capture) begin
            r_above <= (r_row == '0) ? '0 : r_rd_a;
            r_same  <= r_rd_b;
        end
    end

    assign w_ext_rb    = {1'b0, w_below_rep, 1'b0};
    assign w_win_a     = w_ext_a[r_col +: 3];
    assign w_win_s     = w_ext_s[r_col +: 3];
    assign w_win_b     = w_ext_rb[r_col +: 3];
    assign w_rep_count = f_count({w_win_a, w_win_s[2], w_win_s[0], w_win_b});

    always_comb begin
        w_result.cell_alive     = w_in_grid && r_same[w_col_a];
        w_result.neighbor_count = w_rep_count;
        w_result.running        = i_cmd.running;
        w_result.rejected       = i_cmd.rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= w_result;
        end
    end

    assign o_stat.last_row = w_k_last;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out;

endmodule

// File: design/life_cellular_automaton_grid_core.sv
`timescale 1ns / 1ps

// Game of Life grid (rule B3/S23) of 64 by 64 cells held as one row per memory word, with
// cells beyond the border counted as dead. Each input transfer carries one command and
// produces exactly one output transfer: the addressed cell after the command, its live
// neighbor count, the run flag, and whether a toggle was refused because the grid runs.
// Start/stop, clear and read pass through the report states; a toggle first reads and
// rewrites its row. A generation advance while running sweeps the grid: it reads and
// rewrites one row per cycle through the grid memory's single write port, keeping a
// three-row window of old rows in registers. Clear takes effect at once through per-row
// valid bits. A new command is taken once the previous result is in the output register,
// even while that result still waits to be taken.

module life_cellular_automaton_grid_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  lifeca_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output lifeca_pkg::t_out_item o_out_item
);
    import lifeca_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_busy;

    assign o_in_stall = w_busy;

    lifeca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_item.func),
        .i_stat     (w_stat),
        .o_busy     (w_busy),
        .o_cmd      (w_cmd)
    );

    lifeca_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
